[src/folded_partial_additive_osc_assert.svh]
// Assertion macros used by the oscillator sequencer.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef FOLDED_PARTIAL_ADDITIVE_OSC_ASSERT_SVH
`define FOLDED_PARTIAL_ADDITIVE_OSC_ASSERT_SVH

// antecedent implies consequent in the following cycle
`define FPAO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define FPAO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/fpao_pkg.sv]
// Shared types, constants and helpers for the folded partial oscillator.
// No dependencies.
package fpao_pkg;

  localparam int IN_W      = 36;
  localparam int OUT_W     = 24;
  localparam int PHASE_W   = 32;
  localparam int MAX_HARM  = 256;
  localparam int HARM_AW   = $clog2(MAX_HARM);
  localparam int CNT_W     = 9;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 16;
  localparam int DIV_STEPS = 33;
  localparam int DCNT_W    = 6;

  localparam logic [CFG_AW-1:0] CFG_HCOUNT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_TILT   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LEVEL  = 2'd2;

  localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;
  localparam logic signed [32:0] SIN_C4      = -33'sd27;

  typedef enum logic [3:0] {
    S_IDLE, S_RAW, S_CHK, S_MUL, S_WB, S_DIV, S_ACC, S_NEXT, S_FMUL, S_OUT
  } state_t;

  // multiply steps of one harmonic
  typedef enum logic [3:0] {
    OP_X, OP_X2, OP_H3, OP_H2, OP_H1, OP_H0, OP_ONE, OP_S, OP_W
  } op_t;

  typedef struct packed {
    logic        start;
    logic        raw;
    logic        chk;
    logic        mul;
    logic        wb;
    op_t         op;
    logic        div_init;
    logic        div_step;
    logic        acc;
    logic        next;
    logic        fmul;
    logic        oload;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
    logic last;
    logic out_busy;
  } dp_sts_t;

  typedef struct packed {
    logic        [8:0]  hcount;
    logic signed [15:0] tilt;
    logic        [15:0] level;
  } cfg_t;

  // Horner coefficients in Q3.30
  function automatic logic signed [32:0] sin_coef(op_t op);
    logic signed [32:0] c;
    c = '0;
    case (op)
      OP_H3:   c = 33'sd2959;
      OP_H2:   c = -33'sd213044;
      OP_H1:   c = 33'sd8947849;
      OP_H0:   c = -33'sd178956971;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[src/fpao_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fpao_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/fpao_ctrl.sv]
// Sequencer for the oscillator: walks harmonics, multiply steps and divide.
// Depends on fpao_pkg and the assertion macro header.
`include "folded_partial_additive_osc_assert.svh"

module fpao_ctrl import fpao_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  function automatic op_t op_succ(op_t op);
    op_t o;
    o = OP_X;
    case (op)
      OP_X:    o = OP_X2;
      OP_X2:   o = OP_H3;
      OP_H3:   o = OP_H2;
      OP_H2:   o = OP_H1;
      OP_H1:   o = OP_H0;
      OP_H0:   o = OP_ONE;
      OP_ONE:  o = OP_S;
      OP_S:    o = OP_W;
      default: o = OP_X;
    endcase
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_RAW;
        end
      end
      S_RAW: begin
        cmd.raw   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.keep) begin
          op_nxt    = OP_X;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        if (op_r == OP_W) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end else begin
          cmd.wb    = 1'b1;
          op_nxt    = op_succ(op_r);
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (sts.last) begin
          state_nxt = S_FMUL;
        end else begin
          cmd.next  = 1'b1;
          state_nxt = S_RAW;
        end
      end
      S_FMUL: begin
        cmd.fmul  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.oload = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `FPAO_ASSERT_NEXT(a_start_to_raw, state_r == S_IDLE && in_tvalid, state_r == S_RAW, "word taken but sweep did not start")
  `FPAO_ASSERT_NEXT(a_div_len, state_r == S_DIV && cnt_r == DIV_LAST, state_r == S_ACC, "divide ran past its step count")
  `FPAO_ASSERT_NOW(a_div_op, state_r == S_DIV || state_r == S_ACC, op_r == OP_W, "divide without weight product")

endmodule

[src/fpao_dp.sv]
// Datapath: phase update, polynomial sine, weighting divide, sum and output.
// Depends on fpao_pkg; phase store is an external fpao_ram.
module fpao_dp import fpao_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  cfg_t                cfg,
  input  logic [IN_W-1:0]     freq_word,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [OUT_W-1:0]    out_sample,
  output logic                ram_we,
  output logic [HARM_AW-1:0]  ram_waddr,
  output logic [PHASE_W-1:0]  ram_wdata,
  output logic [HARM_AW-1:0]  ram_raddr,
  input  logic [PHASE_W-1:0]  ram_rdata
);

  logic [IN_W-1:0]       w_r;
  logic [CNT_W-1:0]      n_r, nmax_r;
  logic signed [35:0]    sum_r;
  logic [IN_W+CNT_W-1:0] raw_r;
  logic [MAX_HARM-1:0]   vld_r;
  logic                  neg_r;
  logic [30:0]           r_r;
  logic signed [32:0]    x_r, x2_r, acc_r, num_r;
  logic [31:0]           den_r;
  logic signed [65:0]    prod_r;
  logic [31:0]           rem_r;
  logic [32:0]           dsh_r;
  logic                  tneg_r;
  logic signed [52:0]    fprod_r;
  logic [OUT_W-1:0]      out_r;
  logic                  ov_r;

  function automatic logic signed [32:0] rnd30(logic signed [65:0] p);
    logic [65:0] mag, q;
    mag = p[65] ? 66'(-p) : 66'(p);
    q   = (mag + (66'd1 << 29)) >> 30;
    return p[65] ? -33'(q) : 33'(q);
  endfunction

  logic [HARM_AW-1:0]  idx;
  logic [7:0]          d;
  logic                keep;
  logic [31:0]         f0, f, ph, p;
  logic [30:0]         rm, rr;
  logic signed [10:0]  k_s;
  logic signed [26:0]  tk;
  logic [16:0]         dn;
  logic signed [32:0]  num_c;
  logic [31:0]         den_c;
  logic signed [32:0]  ma, mb, rnd;
  logic [65:0]         wmag;
  logic [57:0]         dvd;
  logic [32:0]         dt;
  logic                dge;
  logic [35:0]         term;
  logic [52:0]         fmag;
  logic [31:0]         fq;
  logic signed [32:0]  y;
  logic [OUT_W-1:0]    yc;

  assign idx  = HARM_AW'(n_r - 1'b1);
  assign d    = 8'(nmax_r - 1'b1);
  assign keep = raw_r > (IN_W+CNT_W)'(33'h080000000);

  assign ram_raddr = idx;
  assign ram_waddr = idx;
  assign ram_wdata = p;
  assign ram_we    = cmd.chk & keep;

  always_comb begin
    // fold above-Nyquist increment back into band
    f0    = raw_r[31:0];
    f     = (f0 > 32'h80000000) ? (32'd0 - f0) : f0;
    ph    = vld_r[idx] ? ram_rdata : '0;
    p     = ph + f;
    rm    = p[30:0];
    rr    = (rm > 31'h40000000) ? (31'd0 - rm) : rm;
    k_s   = $signed({2'b00, idx, 1'b0}) - $signed({3'b000, d});
    tk    = cfg.tilt * k_s;
    dn    = d * n_r;
    if (d == 8'd0) begin
      num_c = 33'sd1;
      den_c = {23'd0, n_r};
    end else begin
      num_c = $signed({10'd0, d, 15'd0}) + {{6{tk[26]}}, tk};
      den_c = {dn, 15'd0};
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_X: begin
        ma = $signed({2'b00, r_r});
        mb = HALF_PI_Q30;
      end
      OP_X2: begin
        ma = x_r;
        mb = x_r;
      end
      OP_H3, OP_H2, OP_H1, OP_H0, OP_ONE: begin
        ma = x2_r;
        mb = acc_r;
      end
      OP_S: begin
        ma = x_r;
        mb = acc_r;
      end
      OP_W: begin
        ma = acc_r;
        mb = num_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    rnd = rnd30(prod_r);
  end

  always_comb begin
    wmag = prod_r[65] ? 66'(-prod_r) : 66'(prod_r);
    dvd  = 58'(wmag) + 58'(den_r >> 1);
    dt   = {rem_r, dsh_r[32]};
    dge  = dt >= {1'b0, den_r};
    term = tneg_r ? (36'd0 - {3'd0, dsh_r}) : {3'd0, dsh_r};
    fmag = fprod_r[52] ? 53'(-fprod_r) : 53'(fprod_r);
    fq   = 32'((fmag + (53'd1 << 21)) >> 22);
    y    = fprod_r[52] ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
    if (y > 33'sd8388607) begin
      yc = 24'h7FFFFF;
    end else if (y < -33'sd8388608) begin
      yc = 24'h800000;
    end else begin
      yc = y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (ram_we) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd.oload) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w_r   <= freq_word;
      n_r   <= 9'd1;
      sum_r <= '0;
      if (cfg.hcount == 9'd0) begin
        nmax_r <= 9'd1;
      end else if (cfg.hcount > 9'(MAX_HARM)) begin
        nmax_r <= 9'(MAX_HARM);
      end else begin
        nmax_r <= cfg.hcount;
      end
    end
    if (cmd.raw) begin
      raw_r <= n_r * w_r;
    end
    if (cmd.chk) begin
      neg_r <= p[31];
      r_r   <= rr;
      acc_r <= SIN_C4;
      num_r <= num_c;
      den_r <= den_c;
    end
    if (cmd.mul) begin
      prod_r <= ma * mb;
    end
    if (cmd.wb) begin
      unique case (cmd.op)
        OP_X:                     x_r   <= rnd;
        OP_X2:                    x2_r  <= rnd;
        OP_H3, OP_H2, OP_H1, OP_H0: acc_r <= sin_coef(cmd.op) + rnd;
        OP_ONE:                   acc_r <= Q30_ONE + rnd;
        OP_S:                     acc_r <= neg_r ? -rnd : rnd;
        default:                  acc_r <= acc_r;
      endcase
    end
    if (cmd.div_init) begin
      rem_r  <= {7'd0, dvd[57:33]};
      dsh_r  <= dvd[32:0];
      tneg_r <= prod_r[65];
    end
    if (cmd.div_step) begin
      rem_r <= dge ? 32'(dt - {1'b0, den_r}) : dt[31:0];
      dsh_r <= {dsh_r[31:0], dge};
    end
    if (cmd.acc) begin
      sum_r <= sum_r + $signed(term);
    end
    if (cmd.next) begin
      n_r <= n_r + 1'b1;
    end
    if (cmd.fmul) begin
      fprod_r <= sum_r * $signed({1'b0, cfg.level});
    end
    if (cmd.oload) begin
      out_r <= yc;
    end
  end

  assign sts.keep     = keep;
  assign sts.last     = (n_r == nmax_r);
  assign sts.out_busy = ov_r & ~out_tready;
  assign out_tvalid   = ov_r;
  assign out_sample   = out_r;

endmodule

[src/folded_partial_additive_osc.sv]
// Folded partial oscillator top: configuration registers, sequencer, datapath
// and phase store. Depends on fpao_pkg, fpao_ctrl, fpao_dp and fpao_ram.
//
// Takes one frequency word per sample and returns one Q1.23 sample. Harmonics
// 1..N are visited one after another on a single shared multiplier and a
// one-bit-per-cycle divider: a harmonic at or below Nyquist is dropped after
// its check, one above Nyquist runs 9 multiplies, 33 divide steps and
// bookkeeping. The result sits in an output register, so the next word can
// be taken while it waits. Phases of all harmonics reset to zero.
module folded_partial_additive_osc import fpao_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // [35:0] freq_word
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [23:0] sample
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  logic               ram_we;
  logic [HARM_AW-1:0] ram_waddr, ram_raddr;
  logic [PHASE_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hcount <= 9'd64;
      cfg_r.tilt   <= '0;
      cfg_r.level  <= 16'd32768;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HCOUNT: cfg_r.hcount <= cfg_data[8:0];
        CFG_TILT:   cfg_r.tilt   <= $signed(cfg_data);
        CFG_LEVEL:  cfg_r.level  <= cfg_data;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  fpao_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpao_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg_r),
    .freq_word  (in_tdata[IN_W-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_sample (out_tdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  fpao_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (MAX_HARM)
  ) u_phase_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[test/tb_top.sv]
// Self-checking bench for folded_partial_additive_osc: drives frequency words,
// predicts each Q1.23 sample with a bit-accurate model of the oscillator.
// Depends on fpao_pkg and the oscillator RTL.
module tb_top;
  import fpao_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629713;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;   // [35:0] freq_word
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;       // [23:0] sample
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = CFG_HCOUNT;
  logic [CFG_DW-1:0] cfg_data = '0;

  folded_partial_additive_osc i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_data
  );

  always #5 clk = ~clk;

  // oscillator model state
  logic [31:0]        osc_phase [MAX_HARM];
  logic [8:0]         cur_hcount = 9'd64;
  logic signed [15:0] cur_tilt = '0;
  logic [15:0]        cur_level = 16'd32768;

  logic [35:0]        freq_words [$];
  logic [23:0]        expected_samples [$];
  int                 mismatches = 0;
  bit                 hold_off = 1'b0;

  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return div_round(a * b, Q30);
  endfunction

  function automatic longint sine_q30(logic [31:0] turn);
    longint r, x, x2, acc;
    r = longint'(turn[30:0]);
    if (r > 64'sd1073741824) r = 64'sd2147483648 - r;
    x = (r * HALF_PI + 64'sd536870912) >>> 30;
    x2 = mul_q30(x, x);
    acc = 0;
    acc = -27 + mul_q30(x2, acc);
    acc = 2959 + mul_q30(x2, acc);
    acc = -213044 + mul_q30(x2, acc);
    acc = 8947849 + mul_q30(x2, acc);
    acc = -178956971 + mul_q30(x2, acc);
    acc = Q30 + mul_q30(x2, acc);
    acc = mul_q30(x, acc);
    return turn[31] ? -acc : acc;
  endfunction

  function automatic logic [23:0] predict_sample(logic [35:0] w);
    longint nmax, d, sum, y, raw, f, num, den, s, t;
    logic [31:0] p;
    nmax = cur_hcount;
    t = cur_tilt;
    sum = 0;
    if (nmax < 1) nmax = 1;
    if (nmax > MAX_HARM) nmax = MAX_HARM;
    d = nmax - 1;
    for (longint n = 1; n <= nmax; n++) begin
      raw = n * longint'({28'b0, w});
      if (raw > 64'sd2147483648) begin
        f = raw & 64'hFFFF_FFFF;
        if (f > 64'sd2147483648) f = 64'sd4294967296 - f;
        p = osc_phase[n-1] + f[31:0];
        osc_phase[n-1] = p;
        s = sine_q30(p);
        if (d == 0) begin
          num = 1;
          den = n;
        end else begin
          num = 32768 * d + t * (2 * (n - 1) - d);
          den = 32768 * d * n;
        end
        sum += div_round(s * num, den);
      end
    end
    y = div_round(sum * longint'(cur_level), 64'sd4194304);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return y[23:0];
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
    mismatches++;
  endtask

  // sender: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    logic        nvalid;
    logic [39:0] ndata;
    nvalid = in_tvalid;
    ndata = in_tdata;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_samples.push_back(predict_sample(in_tdata[35:0]));
        nvalid = 1'b0;
      end
      if (!nvalid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (freq_words.size() > 0 && !hold_off) begin
          nvalid = 1'b1;
          ndata = {4'b0, freq_words.pop_front()};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
    end
    in_tvalid <= nvalid;
    in_tdata <= ndata;
  end

  // receiver: stall pattern switches between random modes
  int rx_cycle = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    logic rdy;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample", out_tdata, '0);
      end else begin
        logic [23:0] want;
        want = expected_samples.pop_front();
        if (out_tdata !== want) report_mismatch("sample", out_tdata, want);
      end
    end
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 1) == 0);
      2: rdy = ($urandom_range(0, 7) == 0);
      default: rdy = (rx_cycle % 200) > 150;
    endcase
    out_tready <= rdy;
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (freq_words.size() > 0 || expected_samples.size() > 0 || in_tvalid)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic wait_drained_results();
    @(negedge clk);
    while (expected_samples.size() > 0 || in_tvalid) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      CFG_HCOUNT: cur_hcount = val[8:0];
      CFG_TILT:   cur_tilt = val;
      CFG_LEVEL:  cur_level = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [8:0] hc, logic [15:0] tl, logic [15:0] lv);
    write_reg(CFG_HCOUNT, {7'b0, hc});
    write_reg(CFG_TILT, tl);
    write_reg(CFG_LEVEL, lv);
  endtask

  function automatic logic [35:0] random_word();
    logic [35:0] w;
    int k;
    w = 36'({$urandom(), $urandom()});
    case ($urandom_range(0, 4))
      0, 1: ;
      2, 3: w = w >> $urandom_range(0, 35);
      default: begin
        // near the Nyquist crossing of some harmonic
        k = $urandom_range(1, 16);
        w = 36'((36'h8000_0000 / k) + $urandom_range(0, 4) - 2);
      end
    endcase
    return w;
  endfunction

  task automatic random_phase(int hc, int tl, int lv, int count);
    set_config(9'(hc), 16'(tl), 16'(lv));
    repeat (count) freq_words.push_back(random_word());
    wait_drained();
  endtask

  initial begin
    foreach (osc_phase[i]) osc_phase[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and the Nyquist boundary, reset config
    freq_words = '{36'h0, 36'h1, 36'h7FFF_FFFF, 36'h8000_0000, 36'h8000_0001,
                   36'hFFFF_FFFF, 36'h1_0000_0000, 36'h8_0000_0000,
                   36'hF_FFFF_FFFF, 36'h4000_0000, 36'h4000_0001, 36'h2AAA_AAAB,
                   36'h5555_5555, 36'hC000_0000, 36'h3_3333_3333, 36'hA_5A5A_5A5A,
                   36'h5_A5A5_A5A5, 36'h0200_0001, 36'h0100_0000, 36'h8000_0001};
    wait_drained();
    // pause the sender with results outstanding until all are back, then resume
    repeat (8) freq_words.push_back(random_word());
    @(negedge clk);
    while (expected_samples.size() == 0) @(negedge clk);
    hold_off = 1'b1;
    wait_drained_results();
    hold_off = 1'b0;
    wait_drained();

    random_phase(1, 0, 32768, 100);
    random_phase(0, 16'h8000, 32768, 60);      // count zero acts as one
    random_phase(256, 16'h7FFF, 16'hFFFF, 12); // gain above unity
    random_phase(511, 16'h8000, 0, 8);         // count above the maximum
    random_phase(2, 16'h8000, 32768, 100);
    random_phase(3, 16'h7FFF, 40000, 100);
    repeat (7)
      random_phase($urandom_range(1, 12), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), 92);

    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
